// ===== design/xsr_pkg.sv =====
// Shared types and constants for the xorshift64* ranged generator.
`timescale 1ns / 1ps

package xsr_pkg;

    localparam int unsigned XSR_W = 64;
    localparam int unsigned XSR_HW = XSR_W / 2;
    localparam logic [XSR_W-1:0] XSR_MULT = 64'h2545_F491_4F6C_DD1D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } xsr_state_t;

    // handshake between the sequencer and an arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } xsr_unit_stat_t;

endpackage

// ===== design/xorshift64star_ranged_rng.sv =====
// Top level: xorshift64* generator with result reduced into [range_low, range_high).
// Each item passes through the scramble multiply on a shared 32x32 multiplier, the
// bit-serial remainder and the output stage; an empty range skips the remainder.
// No new item is taken until the last result has been handed to the output register;
// s_tready is high only while idle, and the next item may be taken while a result waits.
// Reset (aresetn low, synchronous): generator state returns to 1, no result pending.
`timescale 1ns / 1ps

module xorshift64star_ranged_rng
    import xsr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // new_seed[63:0], range_low[127:64], range_high[191:128]
    input  logic [0:0]   s_tuser,   // reseed[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // random_value[63:0]
);

    xsr_state_t       state_reg;
    xsr_state_t       state_next;
    logic [XSR_W-1:0] gen_reg;
    logic [XSR_W-1:0] gen_next;
    logic [XSR_W-1:0] low_reg;
    logic [XSR_W-1:0] low_next;
    logic [XSR_W-1:0] high_reg;
    logic [XSR_W-1:0] high_next;
    logic [XSR_W-1:0] result_reg;
    logic [XSR_W-1:0] result_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [XSR_W-1:0] m_data_reg;
    logic [XSR_W-1:0] m_data_next;

    logic             accept;
    logic [XSR_W-1:0] seed_sel;
    logic [XSR_W-1:0] advanced;
    logic [XSR_W-1:0] mul_prod;
    logic [XSR_W-1:0] rem_val;
    logic             div_start;
    xsr_unit_stat_t   mul_stat;
    xsr_unit_stat_t   rem_stat;

    function automatic logic [XSR_W-1:0] xs_advance(input logic [XSR_W-1:0] s);
        logic [XSR_W-1:0] t;
        t = s ^ (s >> 12);
        t = t ^ (t << 25);
        t = t ^ (t >> 27);
        return t;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign seed_sel = s_tuser[0] ? s_tdata[63:0] : gen_reg;
    assign advanced = xs_advance(seed_sel);

    xsr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .operand (advanced),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    xsr_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mul_prod),
        .divisor   (high_reg - low_reg),
        .remainder (rem_val),
        .stat      (rem_stat)
    );

    always_comb begin
        state_next   = state_reg;
        gen_next     = gen_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    gen_next   = advanced;
                    low_next   = s_tdata[127:64];
                    high_next  = s_tdata[191:128];
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    if (high_reg > low_reg) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        // empty range
                        result_next = low_reg;
                        state_next  = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (rem_stat.done) begin
                    result_next = rem_val + low_reg;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        low_reg    <= low_next;
        high_reg   <= high_next;
        result_reg <= result_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gen_reg     <= XSR_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/xsr_mul.sv =====
// Multiply by the xorshift64* constant modulo 2^64 on one shared 32x32 multiplier.
`timescale 1ns / 1ps

module xsr_mul
    import xsr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [XSR_W-1:0] operand,
    output logic [XSR_W-1:0] product,
    output xsr_unit_stat_t   stat
);

    logic [XSR_W-1:0]  a_reg;
    logic [XSR_W-1:0]  a_next;
    logic [XSR_W-1:0]  prod_reg;
    logic [XSR_W-1:0]  prod_next;
    logic [XSR_W-1:0]  acc_reg;
    logic [XSR_W-1:0]  acc_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [XSR_HW-1:0] mul_a;
    logic [XSR_HW-1:0] mul_b;

    // low*low, then the two cross terms, which only reach the upper half
    always_comb begin
        mul_a = (cnt_reg == 2'd1) ? a_reg[XSR_W-1:XSR_HW] : a_reg[XSR_HW-1:0];
        mul_b = (cnt_reg == 2'd2) ? XSR_MULT[XSR_W-1:XSR_HW] : XSR_MULT[XSR_HW-1:0];
    end

    always_comb begin
        a_next    = a_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = operand;
            cnt_next  = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = XSR_W'(mul_a) * XSR_W'(mul_b);
            cnt_next  = cnt_reg + 2'd1;
            case (cnt_reg)
                2'd0: acc_next = acc_reg;
                2'd1: acc_next = prod_reg;
                2'd2: acc_next = acc_reg + {prod_reg[XSR_HW-1:0], {XSR_HW{1'b0}}};
                2'd3: begin
                    acc_next  = acc_reg + {prod_reg[XSR_HW-1:0], {XSR_HW{1'b0}}};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/xsr_rem.sv =====
// Radix-2 restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module xsr_rem
    import xsr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [XSR_W-1:0] dividend,
    input  logic [XSR_W-1:0] divisor,
    output logic [XSR_W-1:0] remainder,
    output xsr_unit_stat_t   stat
);

    localparam int unsigned CNT_W = $clog2(XSR_W);

    logic [XSR_W-1:0] x_reg;
    logic [XSR_W-1:0] x_next;
    logic [XSR_W-1:0] d_reg;
    logic [XSR_W-1:0] d_next;
    logic [XSR_W-1:0] rem_reg;
    logic [XSR_W-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [XSR_W:0]   trial;
    logic [XSR_W:0]   diff;

    assign trial = {rem_reg, x_reg[XSR_W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb begin
        x_next    = x_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = dividend;
            d_next    = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next   = {x_reg[XSR_W-2:0], 1'b0};
            // no borrow means trial >= divisor; result is below divisor either way
            rem_next = diff[XSR_W] ? trial[XSR_W-1:0] : diff[XSR_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(XSR_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/xsr_checker.sv =====
// Port-level checks for the ranged generator, bound to the top level.
`timescale 1ns / 1ps

module xsr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // items taken in but not yet delivered
    always_comb begin
        pend_next = pend_reg;
        if (in_acc && !out_acc) begin
            pend_next = pend_reg + 2'd1;
        end else if (!in_acc && out_acc) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("input ready right after an item was taken");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != 2'd3) && (!m_tvalid || pend_reg != 2'd0))
        else $error("result without a matching item, or too many items in flight");

endmodule

bind xorshift64star_ranged_rng xsr_checker u_xsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the xorshift64* ranged random number generator.
`timescale 1ns / 1ps

module testbench;
    import xsr_pkg::*;

    localparam int unsigned SHIFT_A     = 12;
    localparam int unsigned SHIFT_B     = 25;
    localparam int unsigned SHIFT_C     = 27;
    localparam int unsigned N_RANDOM    = 1930;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_WAIT  = 100;
    localparam bit [63:0]   ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam bit [63:0]   TOP_BIT     = 64'h8000_0000_0000_0000;

    // Tracks the generator state and the values the block must return, oldest first.
    class rng_scoreboard;
        bit [63:0]   gen_state;
        bit [63:0]   pending_values[$];
        int unsigned mismatches;
        int unsigned values_checked;
        int unsigned requests;
        int unsigned reseeds;
        int unsigned empty_ranges;
        int unsigned zero_states;

        function new();
            gen_state = 64'd1;
        endfunction

        function void note_request(bit reseed, bit [63:0] seed, bit [63:0] lo, bit [63:0] hi);
            bit [63:0] s;
            bit [63:0] scrambled;
            s = reseed ? seed : gen_state;
            s ^= s >> SHIFT_A;
            s ^= s << SHIFT_B;
            s ^= s >> SHIFT_C;
            gen_state = s;
            scrambled = s * XSR_MULT;
            requests++;
            if (reseed)
                reseeds++;
            if (s == 64'd0)
                zero_states++;
            if (hi > lo) begin
                pending_values.push_back(scrambled % (hi - lo) + lo);
            end else begin
                empty_ranges++;
                pending_values.push_back(lo);
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_value(bit [63:0] got);
            bit [63:0] want;
            if (pending_values.size() == 0) begin
                report_mismatch($sformatf("random_value %h arrived with none expected", got));
            end else begin
                want = pending_values.pop_front();
                values_checked++;
                if (got !== want)
                    report_mismatch($sformatf("random_value %h, expected %h (result %0d)",
                                              got, want, values_checked));
            end
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;

    rng_scoreboard sb = new();
    int unsigned   results_taken = 0;
    int unsigned   quiet_cycles = 0;
    bit            tx_calm = 1'b0;

    xorshift64star_ranged_rng dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Offers one item after a random gap (none while calm) and returns at the edge where it is taken.
    task automatic send_request(input bit reseed, input bit [63:0] seed,
                                input bit [63:0] lo, input bit [63:0] hi);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= reseed;
        s_tdata  <= {hi, lo, seed};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(reseed, seed, lo, hi);
    endtask

    task automatic send_random_request();
        bit          reseed;
        bit [63:0]   seed;
        bit [63:0]   lo;
        bit [63:0]   hi;
        int unsigned shift;
        reseed = ($urandom_range(0, 7) == 0);
        seed   = ($urandom_range(0, 19) == 0) ? 64'd0 : rand64();
        lo     = rand64();
        case ($urandom_range(0, 9))
            0: begin
                // empty range, equal or reversed bounds, unless the subtraction wraps
                hi = $urandom_range(0, 1) ? lo : lo - $urandom_range(1, 1000);
            end
            1: begin
                lo = $urandom_range(0, 1) ? 64'd0 : {32'd0, $urandom()};
                hi = ALL_ONES - $urandom_range(0, 3);
            end
            2, 3, 4: begin
                hi = lo + $urandom_range(1, 16);
            end
            5, 6: begin
                hi = rand64();
            end
            7: begin
                shift = $urandom_range(0, 63);
                lo    = lo >> 1;
                hi    = lo + (64'd1 << shift);
            end
            8: begin
                lo = {32'd0, $urandom()};
                hi = TOP_BIT | rand64();
            end
            default: begin
                hi = ALL_ONES;
            end
        endcase
        send_request(reseed, seed, lo, hi);
    endtask

    // Result side: random stalls, plus two long hold-offs that back the block up.
    initial begin
        int unsigned gap;
        bit          rx_calm;
        rx_calm = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_taken % 64 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            gap = rx_calm ? 0 : $urandom_range(0, 9);
            if (results_taken == 200 || results_taken == 1000)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_taken++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_value(m_tdata);
    end

    // Watchdog: ends the run if no item moves on either side for too long.
    initial begin
        while (!aresetn) @(posedge aclk);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first draw from the reset state, range extremes, zero state
        send_request(1'b0, 64'd0, 64'd0, ALL_ONES);
        send_request(1'b0, 64'd0, 64'd5, 64'd5);
        send_request(1'b0, 64'd0, ALL_ONES, 64'd0);
        send_request(1'b0, 64'd0, ALL_ONES - 1, ALL_ONES);
        send_request(1'b0, 64'd0, 64'd0, 64'd1);
        send_request(1'b1, ALL_ONES, 64'd0, ALL_ONES);
        send_request(1'b1, TOP_BIT, 64'd0, TOP_BIT);
        send_request(1'b0, 64'd0, TOP_BIT, ALL_ONES);
        send_request(1'b0, 64'd0, 64'd100, 64'd107);
        send_request(1'b1, 64'd0, 64'd0, ALL_ONES);
        send_request(1'b0, ALL_ONES, 64'd0, ALL_ONES);
        send_request(1'b0, 64'd0, 64'd3, 64'd1000);
        send_request(1'b0, 64'd0, ALL_ONES, ALL_ONES);
        send_request(1'b1, 64'h5555_5555_5555_5555, 64'd0, ALL_ONES);
        send_request(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, ALL_ONES);
        send_request(1'b0, ALL_ONES, 64'd1, 64'h0000_0001_0000_0001);
        send_request(1'b0, 64'd0, 64'd0, 64'd3);
        send_request(1'b1, 64'd1, 64'd0, 64'd2);
        send_request(1'b0, 64'd0, ALL_ONES - 64'd9, 64'd10);

        for (int unsigned i = 0; i < N_RANDOM; i++) begin
            if (i % 64 == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            send_random_request();
        end
        s_tvalid <= 1'b0;

        while (sb.pending_values.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.pending_values.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.pending_values.size()));

        $display("Sent %0d requests: %0d reseeds, %0d empty ranges, %0d from a zero state",
                 sb.requests, sb.reseeds, sb.empty_ranges, sb.zero_states);
        $display("Checked %0d results with two long output hold-offs, %0d mismatches",
                 sb.values_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
